// ===== rtl/sssp_pkg.sv =====
// Shared types and constants for the single source shortest path block.
package sssp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 8;
  localparam int DIST_BITS        = 12;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 12'hFFF;
  localparam logic [4:0] VCOUNT_RESET = 5'd10;
  localparam logic [3:0] START_RESET  = 4'd0;

  typedef enum logic [0:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_START_VERTEX = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
    logic [7:0] weight;
    logic       last_edge;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  vertex;
    logic [11:0] distance;
    logic        unreachable;
    logic        last_result;
  } out_item_t;

endpackage

// ===== rtl/sssp_front.sv =====
// Front end: accepts edge items and queues them for the search engine.
module sssp_front #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int DEPTH        = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sssp_pkg::in_item_t   in_data,
  output logic                 q_valid,
  input  logic                 q_take,
  output sssp_pkg::in_item_t   q_data,
  output logic                 q_keep
);
  localparam int PW = $clog2(DEPTH);

  sssp_pkg::in_item_t mem_r [DEPTH];
  logic               keep_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push, pop, keep_in;

  // edges with an endpoint beyond storage are dropped from the matrix write
  assign keep_in = ({28'd0, in_data.vertex_a} < MAX_VERTICES) &&
                   ({28'd0, in_data.vertex_b} < MAX_VERTICES);

  assign in_stall = (cnt_r == (PW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_take;
  assign q_data   = mem_r[rp_r];
  assign q_keep   = keep_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      mem_r[wp_r]  <= in_data;
      keep_r[wp_r] <= keep_in;
    end
  end
endmodule

// ===== rtl/sssp_engine.sv =====
// Back end: weight matrix, Dijkstra search sequencer and result output.
module sssp_engine #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_take,
  input  sssp_pkg::in_item_t   q_data,
  input  logic                 q_keep,
  input  logic [4:0]           vertex_count,
  input  logic [3:0]           start_vertex,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sssp_pkg::out_item_t  out_data
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VW;
  // matrix is addressed as {row, column}, so it spans the full power-of-two square
  localparam int DEPTH = 1 << AW;
  localparam int DW = sssp_pkg::DIST_BITS + 1 + WEIGHT_BITS;
  localparam int CW = VW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_MIRROR, S_INIT, S_SEL, S_RELAX_RD, S_RELAX,
    S_EMIT, S_DONE
  } state_t;

  state_t state_r;
  logic [WEIGHT_BITS-1:0] mat_r [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_r;
  logic [DW-1:0]  dist_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reach_r, vis_r;
  logic [AW-1:0]  clr_r;
  logic [VW-1:0]  a_r, b_r, i_r, best_r, src_r;
  logic [CW-1:0]  n_r, round_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic           last_r, found_r;
  logic           out_valid_r;
  sssp_pkg::out_item_t out_r;

  logic           wr_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic [CW-1:0]  n_eff, src_eff;
  logic [DW-1:0]  cand;
  logic           out_free;
  logic           emit_now;

  always_comb begin
    n_eff = (vertex_count < 5'd2) ? CW'(2) :
            ({27'd0, vertex_count} > MAX_VERTICES) ? CW'(MAX_VERTICES) :
            CW'(vertex_count);
    src_eff = ({28'd0, start_vertex} >= 32'(n_eff)) ? n_eff - 1'b1 : CW'(start_vertex);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit_now = (state_r == S_EMIT) && out_free && (i_r != src_r);
  assign q_take   = (state_r == S_LOAD);
  assign cand     = dist_r[best_r] + DW'(rd_r);
  assign rd_addr  = {best_r, i_r};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_r;
    wr_data = '0;
    unique case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_LOAD: begin
        wr_en   = q_valid && q_keep;
        wr_addr = {VW'(q_data.vertex_a), VW'(q_data.vertex_b)};
        wr_data = WEIGHT_BITS'(q_data.weight);
      end
      S_MIRROR: begin
        wr_en   = 1'b1;
        wr_addr = {b_r, a_r};
        wr_data = w_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mat_r[wr_addr] <= wr_data;
    rd_r <= mat_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vis_r       <= '0;
      reach_r     <= '0;
    end else begin
      out_valid_r <= emit_now || (out_valid_r && out_stall);
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH-1)) state_r <= S_LOAD;
        end
        S_LOAD: if (q_valid) begin
          a_r    <= VW'(q_data.vertex_a);
          b_r    <= VW'(q_data.vertex_b);
          w_r    <= WEIGHT_BITS'(q_data.weight);
          last_r <= q_data.last_edge;
          if (q_keep) state_r <= S_MIRROR;
          else if (q_data.last_edge) state_r <= S_INIT;
        end
        S_MIRROR: state_r <= last_r ? S_INIT : S_LOAD;
        S_INIT: begin
          n_r     <= n_eff;
          src_r   <= src_eff[VW-1:0];
          vis_r   <= '0;
          reach_r <= MAX_VERTICES'(1) << src_eff[VW-1:0];
          dist_r[src_eff[VW-1:0]]  <= '0;
          round_r <= '0;
          i_r     <= '0;
          found_r <= 1'b0;
          state_r <= S_SEL;
        end
        S_SEL: begin
          // linear scan for the lowest-index minimum among reached, unvisited
          if (!vis_r[i_r] && reach_r[i_r] &&
              (!found_r || dist_r[i_r] < dist_r[best_r])) begin
            best_r  <= i_r;
            found_r <= 1'b1;
          end
          if (CW'(i_r) == n_r - 1'b1) begin
            i_r <= '0;
            if (found_r || (!vis_r[i_r] && reach_r[i_r])) state_r <= S_RELAX_RD;
            else state_r <= S_EMIT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_RELAX_RD: begin
          vis_r[best_r] <= 1'b1;
          state_r <= S_RELAX;
        end
        S_RELAX: begin
          if (!vis_r[i_r] && rd_r != '0 && (!reach_r[i_r] || cand < dist_r[i_r])) begin
            dist_r[i_r]  <= cand;
            reach_r[i_r] <= 1'b1;
          end
          if (CW'(i_r) == n_r - 1'b1) begin
            i_r     <= '0;
            found_r <= 1'b0;
            round_r <= round_r + 1'b1;
            state_r <= (round_r + 2'd2 < n_r) ? S_SEL : S_EMIT;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RELAX_RD;
          end
        end
        S_EMIT: if (out_free) begin
          if (i_r != src_r) begin
            out_r.vertex      <= 4'(i_r);
            out_r.unreachable <= !reach_r[i_r];
            out_r.distance    <= !reach_r[i_r] ? '0 :
              (dist_r[i_r] > DW'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX :
              dist_r[i_r][sssp_pkg::DIST_BITS-1:0];
            out_r.last_result <= (CW'(i_r) == n_r - 1'b1) ||
                                 (CW'(src_r) == n_r - 1'b1 && CW'(i_r) == n_r - 2'd2);
          end
          if ((CW'(i_r) == n_r - 1'b1) ||
              (CW'(src_r) == n_r - 1'b1 && CW'(i_r) == n_r - 2'd2 && i_r != src_r)) begin
            clr_r   <= '0;
            state_r <= S_DONE;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_DONE: state_r <= S_CLEAR;
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ===== rtl/single_source_shortest_path.sv =====
// Top level of the single source shortest path block.
// Usage: edges enter on in_* (valid/stall), one item a cycle while in_stall is low,
// into a two-entry queue; the engine stores each kept edge in both matrix halves,
// first the given entry, then its mirror. An item with last_edge set starts
// the search over vertex_count vertices (clamped to 2..MAX_VERTICES) from
// start_vertex. The search scans all vertices for the minimum and then
// relaxes each neighbor, in up to V-1 rounds. One result per vertex other
// than the start follows on out_* in ascending order, last_result on the
// final one; a stalled result holds its payload. After the run the matrix
// is cleared one entry a cycle (the full power-of-two square, at least
// MAX_VERTICES^2 entries), during which no edge is taken from the queue.
// Reset runs the same clearing pass first.
// Configuration writes on cfg_* are always ready; write only while idle.
// The engine takes no new edge until the current one is mirrored, as the matrix has a single write port.
module single_source_shortest_path #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sssp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sssp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);
  logic [4:0] vcount_r;
  logic [3:0] start_r;
  logic q_valid, q_take, q_keep;
  sssp_pkg::in_item_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= sssp_pkg::VCOUNT_RESET;
      start_r  <= sssp_pkg::START_RESET;
    end else if (cfg_valid) begin
      unique case (sssp_pkg::cfg_index_t'(cfg_index))
        sssp_pkg::CFG_VERTEX_COUNT: vcount_r <= cfg_data;
        sssp_pkg::CFG_START_VERTEX: start_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sssp_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data, .q_keep
  );

  sssp_engine #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_take, .q_data, .q_keep,
    .vertex_count(vcount_r), .start_vertex(start_r),
    .out_valid, .out_stall, .out_data
  );
endmodule

// ===== rtl/sssp_checker.sv =====
// Port-level checks for the shortest path block, bound to the top level.
module sssp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input sssp_pkg::out_item_t out_data,
  input logic                cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unreachable |-> out_data.distance == '0)
    else $error("unreachable result has a distance");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result ##1 out_valid |->
    out_data.vertex > $past(out_data.vertex))
    else $error("results out of vertex order");
endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_data, .cfg_ready
);
